### rtl/core/rspd_pkg.sv
// shared types and constants for the ramped setpoint pi position drive
`timescale 1ns / 1ps
package rspd_pkg;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_MODE = 2'd1,
      OP_GAIN = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   localparam int ANGLE_W = 16;
   localparam int ERR_W   = 17;
   localparam int SUM_W   = 40;
   localparam int LO_W    = 20;
   localparam int TOTAL_W = 58;
   localparam int FRAC_W  = 24;

   localparam logic [15:0] KP_RESET = 16'd474;
   localparam logic signed [TOTAL_W-1:0] DRIVE_LIMIT = 58'sd1677721600;
   localparam logic signed [7:0] DRIVE_MAX = 8'sd100;
   localparam logic signed [7:0] DRIVE_MIN = -8'sd100;

   typedef struct packed {
      opcode_type                 opcode;
      logic signed [ANGLE_W-1:0]  measured;
      logic                       direction;
      logic signed [ANGLE_W-1:0]  target;
      logic [15:0]                hold;
      logic [7:0]                 step;
      logic [15:0]                kp;
   } request_type;

   typedef struct packed {
      logic                       dir;
      logic signed [ANGLE_W-1:0]  setpoint;
      logic signed [ANGLE_W-1:0]  target;
      logic [15:0]                hold;
      logic [7:0]                 step;
      logic [15:0]                count;
      logic signed [ERR_W-1:0]    err;
      logic signed [SUM_W-1:0]    sum;
      logic [15:0]                kp;
   } ramp_state_type;

   // ramp downward, default gain, everything else cleared
   localparam ramp_state_type STATE_RESET = '{dir: 1'b1, kp: KP_RESET, default: '0};

endpackage

### rtl/core/rspd_ramp.sv
// next controller state for one beat: setpoint ramp, error and saturating integral
`timescale 1ns / 1ps
module rspd_ramp (
   input  rspd_pkg::request_type    req,
   input  rspd_pkg::ramp_state_type cur,
   output rspd_pkg::ramp_state_type nxt
);
   import rspd_pkg::*;

   logic [15:0]               count_inc;
   logic                      active;
   logic                      step_due;
   logic signed [17:0]        sp_step;
   logic signed [ANGLE_W-1:0] sp_sat;
   logic signed [ERR_W-1:0]   err_new;
   logic signed [SUM_W:0]     sum_ext;
   logic signed [SUM_W-1:0]   sum_sat;

   always_comb begin
      count_inc = (cur.count == 16'hFFFF) ? cur.count : cur.count + 16'd1;
      active    = cur.dir ? (cur.setpoint >= cur.target) : (cur.setpoint <= cur.target);
      step_due  = count_inc >= cur.hold;
      err_new   = active ? (ERR_W'(cur.setpoint) - ERR_W'(req.measured)) : cur.err;

      if (cur.dir) begin
         sp_step = 18'(cur.setpoint) - $signed({10'd0, cur.step});
      end else begin
         sp_step = 18'(cur.setpoint) + $signed({10'd0, cur.step});
      end
      if (sp_step > 18'sd32767) begin
         sp_sat = 16'sh7FFF;
      end else if (sp_step < -18'sd32768) begin
         sp_sat = 16'sh8000;
      end else begin
         sp_sat = $signed(sp_step[ANGLE_W-1:0]);
      end

      // integral saturates at the 40 bit signed limits
      sum_ext = (SUM_W+1)'(cur.sum) + (SUM_W+1)'(err_new);
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
         sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = $signed(sum_ext[SUM_W-1:0]);
      end
   end

   always_comb begin
      nxt = cur;
      unique case (req.opcode)
         OP_TICK: begin
            nxt.count = (active && step_due) ? 16'd0 : count_inc;
            if (active) begin
               nxt.setpoint = step_due ? sp_sat : cur.setpoint;
            end else begin
               nxt.setpoint = cur.target;
            end
            nxt.err = err_new;
            nxt.sum = sum_sat;
         end
         OP_MODE: begin
            // a change of direction restarts the ramp from where the motor is
            if (req.direction != cur.dir) begin
               nxt.setpoint = req.measured;
            end
            nxt.dir    = req.direction;
            nxt.target = req.target;
            nxt.hold   = req.hold;
            nxt.step   = req.step;
         end
         OP_GAIN: begin
            nxt.kp = req.kp;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

### rtl/core/ramped_setpoint_pi_position_drive_core.sv
// top level: ramped setpoint pi position drive with four stage output pipeline
`timescale 1ns / 1ps
// Each beat on req_ is a tick (measured angle), a mode command or a gain command,
// and gives exactly one beat on rsp_ carrying drive, setpoint and at_limit.
// A new beat can be taken every cycle while rsp_ready is held high. The controller
// state (setpoint, hold counter, error and 40 bit integral) is registered as the
// beat is taken, which sets the one-beat-per-cycle rate; the PI products (one
// 17x17, one 17x20 and one 16x20 multiplier) and the clamp follow in three
// further registered stages. Commands report drive 0 and at_limit 0. The user
// must write integral_gain through csr_ only while no beat is in flight; the
// block itself does not enforce this.
module ramped_setpoint_pi_position_drive_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic signed [15:0]  req_measured_angle,
   input  logic                req_direction,
   input  logic signed [15:0]  req_target_angle,
   input  logic [15:0]         req_hold_ticks,
   input  logic [7:0]          req_step_size,
   input  logic [15:0]         req_gain_kp,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [7:0]   rsp_drive,
   output logic signed [15:0]  rsp_setpoint,
   output logic                rsp_at_limit
);
   import rspd_pkg::*;

   request_type               req;
   ramp_state_type            state_ff, state_in;
   logic [15:0]               igain_ff;
   logic                      req_fire;

   logic                      s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic                      en1, en2, en3, en_out;

   logic                      s1_tick_ff;
   logic signed [ERR_W-1:0]   s1_err_ff;
   logic signed [SUM_W-1:0]   s1_sum_ff;
   logic [15:0]               s1_kp_ff;
   logic signed [ANGLE_W-1:0] s1_sp_ff;

   logic                      s2_tick_ff;
   logic signed [33:0]        s2_prop_ff, s2_prop_in;
   logic signed [36:0]        s2_ihi_ff, s2_ihi_in;
   logic [35:0]               s2_ilo_ff, s2_ilo_in;
   logic signed [ANGLE_W-1:0] s2_sp_ff;

   logic                      s3_tick_ff;
   logic signed [TOTAL_W-1:0] s3_total_ff, s3_total_in;
   logic signed [ANGLE_W-1:0] s3_sp_ff;

   logic signed [7:0]         drive_ff, drive_in;
   logic                      lim_ff, lim_in;
   logic signed [ANGLE_W-1:0] sp_ff;

   assign req.opcode    = opcode_type'(req_opcode);
   assign req.measured  = req_measured_angle;
   assign req.direction = req_direction;
   assign req.target    = req_target_angle;
   assign req.hold      = req_hold_ticks;
   assign req.step      = req_step_size;
   assign req.kp        = req_gain_kp;

   rspd_ramp u_ramp (
      .req (req),
      .cur (state_ff),
      .nxt (state_in)
   );

   // each stage moves on when the one after it is empty or moving
   assign en_out    = !out_v_ff || rsp_ready;
   assign en3       = !s3_v_ff || en_out;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_ready = en1;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         igain_ff       <= 16'd0;
         state_ff       <= STATE_RESET;
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
         s3_v_ff        <= 1'b0;
         out_v_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            igain_ff <= csr_wdata;
         end
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (en1) begin
            s1_v_ff <= req_valid;
         end
         if (en2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (en3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (en_out) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   always_comb begin
      s2_prop_in  = 34'($signed({1'b0, s1_kp_ff})) * 34'(s1_err_ff);
      s2_ihi_in   = 37'($signed({1'b0, igain_ff})) * 37'($signed(s1_sum_ff[SUM_W-1:LO_W]));
      s2_ilo_in   = 36'(igain_ff) * 36'(s1_sum_ff[LO_W-1:0]);
      s3_total_in = $signed((TOTAL_W'(s2_prop_ff) <<< 16) + (TOTAL_W'(s2_ihi_ff) <<< LO_W)
                            + TOTAL_W'(s2_ilo_ff));
   end

   // clamp, otherwise truncate toward zero
   always_comb begin
      drive_in = 8'sd0;
      lim_in   = 1'b0;
      if (s3_tick_ff) begin
         if (s3_total_ff > DRIVE_LIMIT) begin
            drive_in = DRIVE_MAX;
            lim_in   = 1'b1;
         end else if (s3_total_ff < -DRIVE_LIMIT) begin
            drive_in = DRIVE_MIN;
            lim_in   = 1'b1;
         end else if (s3_total_ff[TOTAL_W-1] && (s3_total_ff[FRAC_W-1:0] != '0)) begin
            drive_in = $signed(s3_total_ff[FRAC_W+7:FRAC_W]) + 8'sd1;
         end else begin
            drive_in = $signed(s3_total_ff[FRAC_W+7:FRAC_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_tick_ff <= (req.opcode == OP_TICK);
         s1_err_ff  <= state_in.err;
         s1_sum_ff  <= state_in.sum;
         s1_kp_ff   <= state_in.kp;
         s1_sp_ff   <= state_in.setpoint;
      end
      if (en2) begin
         s2_tick_ff <= s1_tick_ff;
         s2_prop_ff <= s2_prop_in;
         s2_ihi_ff  <= s2_ihi_in;
         s2_ilo_ff  <= s2_ilo_in;
         s2_sp_ff   <= s1_sp_ff;
      end
      if (en3) begin
         s3_tick_ff  <= s2_tick_ff;
         s3_total_ff <= s3_total_in;
         s3_sp_ff    <= s2_sp_ff;
      end
      if (en_out) begin
         drive_ff <= drive_in;
         lim_ff   <= lim_in;
         sp_ff    <= s3_sp_ff;
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_drive    = drive_ff;
   assign rsp_setpoint = sp_ff;
   assign rsp_at_limit = lim_ff;

   a_limit_drive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_limit |-> (rsp_drive == DRIVE_MAX || rsp_drive == DRIVE_MIN))
      else $error("at_limit set without a clamped drive");

   a_drive_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive <= DRIVE_MAX && rsp_drive >= DRIVE_MIN))
      else $error("drive out of range");

   a_sum_only_on_tick : assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req.opcode == OP_TICK) |=> $stable(state_ff.sum))
      else $error("integral moved without a tick beat");

   a_cmd_zero_drive : assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && !s3_tick_ff && en_out |=> (rsp_drive == 8'sd0 && !rsp_at_limit))
      else $error("command beat gave a non-zero drive");

   a_dir_change_load : assert property (@(posedge clock) disable iff (reset)
      req_fire && req.opcode == OP_MODE && req_direction != state_ff.dir
      |=> state_ff.setpoint == $past(req_measured_angle))
      else $error("direction change did not load the setpoint");

endmodule
